// ===== rtl/vspc_pkg.sv =====
// Shared types and constants for the version string parse/compare unit.
// Used by the front, back and top modules; no dependencies of its own.

package vspc_pkg;

  localparam int unsigned NumW      = 32;
  localparam int unsigned SuffixLen = 8;

  // Fixed separator that sits between the third and the fourth number.
  localparam logic [7:0] SUFFIX_CHARS [SuffixLen] = '{
    8'h2d, 8'h6b, 8'h69, 8'h6d, 8'h63, 8'h68, 8'h69, 8'h2e
  };

  localparam logic [7:0] CH_V    = 8'h76;
  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    CFG_MAJOR = 3'd0,
    CFG_MINOR = 3'd1,
    CFG_PATCH = 3'd2,
    CFG_BUILD = 3'd3,
    CFG_VALID = 3'd4
  } cfg_idx_e;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic                 last;
    logic                 is_digit;
    logic [3:0]           digit;
    logic                 is_v;
    logic                 is_dot;
    logic [SuffixLen-1:0] sfx_hit;
  } char_class_t;

  typedef struct packed {
    logic [NumW-1:0] major;
    logic [NumW-1:0] minor;
    logic [NumW-1:0] patch;
    logic [NumW-1:0] build;
    logic            valid;
  } inst_cfg_t;

  typedef struct packed {
    logic            ok;
    logic            newer;
    logic [NumW-1:0] major;
    logic [NumW-1:0] minor;
    logic [NumW-1:0] patch;
    logic [NumW-1:0] build;
  } result_t;

endpackage

// ===== rtl/vspc_fifo.sv =====
// Small register-based queue with push/full and pop/empty sides.
// Generic; used between front and back and on the result side.

module vspc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/vspc_front.sv =====
// Front end: classifies each incoming character for the parser.
// Depends on vspc_pkg for the class record and character constants.

module vspc_front (
  input  logic [7:0]             char_code_i,
  input  logic                   last_char_i,
  output vspc_pkg::char_class_t  class_o
);

  always_comb begin
    class_o.last     = last_char_i;
    class_o.is_digit = (char_code_i >= vspc_pkg::CH_ZERO) &&
                       (char_code_i <= vspc_pkg::CH_NINE);
    class_o.digit    = 4'(char_code_i - vspc_pkg::CH_ZERO);
    class_o.is_v     = (char_code_i == vspc_pkg::CH_V);
    class_o.is_dot   = (char_code_i == vspc_pkg::CH_DOT);
    for (int k = 0; k < vspc_pkg::SuffixLen; k++) begin
      class_o.sfx_hit[k] = (char_code_i == vspc_pkg::SUFFIX_CHARS[k]);
    end
  end

endmodule

// ===== rtl/vspc_back.sv =====
// Back end: parse state machine, digit accumulator and the version compare.
// Depends on vspc_pkg; takes classified characters from the front queue.

module vspc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   mid_valid_i,
  input  vspc_pkg::char_class_t  mid_data_i,
  output logic                   mid_pop_o,
  input  vspc_pkg::inst_cfg_t    cfg_i,
  output logic                   out_push_o,
  output vspc_pkg::result_t      result_o,
  input  logic                   out_full_i
);

  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_NUM0  = 4'd1,
    PH_NUM1  = 4'd2,
    PH_NUM2  = 4'd3,
    PH_SUF1  = 4'd5,
    PH_SUF2  = 4'd6,
    PH_SUF3  = 4'd7,
    PH_SUF4  = 4'd8,
    PH_SUF5  = 4'd9,
    PH_SUF6  = 4'd10,
    PH_SUF7  = 4'd11,
    PH_NUM3  = 4'd12,
    PH_FAIL  = 4'd13
  } phase_e;

  localparam int unsigned NumW = vspc_pkg::NumW;

  phase_e             phase_q, phase_d, eff;
  logic [NumW-1:0]    acc_q, acc_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               fz_q, fz_d;
  logic [NumW-1:0]    cap_q [3];
  logic [NumW-1:0]    cap_d [3];
  logic               stg_vld_q, stg_vld_d;
  vspc_pkg::result_t  stg_q, stg_d;

  vspc_pkg::char_class_t in;
  logic               stg_ready, take, dig_ok, ok;
  logic [NumW+3:0]    prod;
  logic [1:0]         cap_idx;
  logic [2:0]         sidx;

  always_comb begin
    in        = mid_data_i;
    stg_ready = !stg_vld_q || !out_full_i;
    take      = mid_valid_i && (!in.last || stg_ready);
    eff       = (phase_q == PH_START) ? PH_NUM0 : phase_q;
    prod      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (NumW+4)'(in.digit);
    dig_ok    = !(|prod[NumW+3:NumW]) && !((cnt_q != 2'd0) && fz_q);
    cap_idx   = eff[1:0] - 2'd1;
    sidx      = 3'(eff - 4'd4);

    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    fz_d      = fz_q;
    cap_d     = cap_q;
    stg_vld_d = stg_vld_q;
    stg_d     = stg_q;
    ok        = 1'b0;

    if (stg_vld_q && !out_full_i) begin
      stg_vld_d = 1'b0;
    end

    if (take) begin
      if ((phase_q == PH_START) && in.is_v) begin
        phase_d = PH_NUM0;
      end else begin
        phase_d = eff;
        case (eff)
          PH_NUM0, PH_NUM1, PH_NUM2: begin
            if (in.is_digit) begin
              if (dig_ok) begin
                acc_d = prod[NumW-1:0];
                if (cnt_q == 2'd0) fz_d = (in.digit == 4'd0);
                if (cnt_q != 2'd2) cnt_d = cnt_q + 2'd1;
              end else begin
                phase_d = PH_FAIL;
              end
            end else if (cnt_q == 2'd0) begin
              phase_d = PH_FAIL;
            end else begin
              for (int k = 0; k < 3; k++) begin
                if (cap_idx == 2'(k)) cap_d[k] = acc_q;
              end
              acc_d = '0;
              cnt_d = 2'd0;
              fz_d  = 1'b0;
              if (eff == PH_NUM2) begin
                phase_d = in.sfx_hit[0] ? PH_SUF1 : PH_FAIL;
              end else begin
                phase_d = in.is_dot ? phase_e'(eff + 4'd1) : PH_FAIL;
              end
            end
          end
          PH_SUF1, PH_SUF2, PH_SUF3, PH_SUF4, PH_SUF5, PH_SUF6, PH_SUF7: begin
            if (!in.sfx_hit[sidx]) begin
              phase_d = PH_FAIL;
            end else if (eff == PH_SUF7) begin
              phase_d = PH_NUM3;
            end else begin
              phase_d = phase_e'(eff + 4'd1);
            end
          end
          PH_NUM3: begin
            if (in.is_digit && dig_ok) begin
              acc_d = prod[NumW-1:0];
              if (cnt_q == 2'd0) fz_d = (in.digit == 4'd0);
              if (cnt_q != 2'd2) cnt_d = cnt_q + 2'd1;
            end else begin
              phase_d = PH_FAIL;
            end
          end
          default: begin
            phase_d = PH_FAIL;
          end
        endcase
      end

      // Close out the string: capture the result, then clear the parser.
      if (in.last) begin
        ok          = (phase_d == PH_NUM3) && (cnt_d != 2'd0) && (acc_d != '0);
        stg_vld_d   = 1'b1;
        stg_d.ok    = ok;
        stg_d.newer = 1'b0;
        stg_d.major = ok ? cap_q[0] : '0;
        stg_d.minor = ok ? cap_q[1] : '0;
        stg_d.patch = ok ? cap_q[2] : '0;
        stg_d.build = ok ? acc_d : '0;
        phase_d     = PH_START;
        acc_d       = '0;
        cnt_d       = 2'd0;
        fz_d        = 1'b0;
        for (int k = 0; k < 3; k++) begin
          cap_d[k] = '0;
        end
      end
    end
  end

  assign mid_pop_o  = take;
  assign out_push_o = stg_vld_q && !out_full_i;

  // Lexicographic compare against the installed version.
  always_comb begin
    logic gt0, gt1, gt2, gt3, eq0, eq1, eq2;
    gt0 = stg_q.major > cfg_i.major;
    gt1 = stg_q.minor > cfg_i.minor;
    gt2 = stg_q.patch > cfg_i.patch;
    gt3 = stg_q.build > cfg_i.build;
    eq0 = stg_q.major == cfg_i.major;
    eq1 = stg_q.minor == cfg_i.minor;
    eq2 = stg_q.patch == cfg_i.patch;
    result_o       = stg_q;
    result_o.newer = stg_q.ok && cfg_i.valid &&
                     (gt0 || (eq0 && (gt1 || (eq1 && (gt2 || (eq2 && gt3))))));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      acc_q     <= '0;
      cnt_q     <= 2'd0;
      fz_q      <= 1'b0;
      cap_q     <= '{default: '0};
      stg_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      fz_q      <= fz_d;
      cap_q     <= cap_d;
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

endmodule

// ===== rtl/version_string_parse_compare_unit.sv =====
// Top level of the version string parse/compare unit.
// Depends on vspc_pkg, vspc_front, vspc_fifo and vspc_back.
//
// Usage:
//   Characters enter through a queue-style port: an item is taken at a clock
//   edge with push high and full low. last_char_i marks the final character;
//   only that character produces a result. Results leave through a second
//   queue-style port: while empty is low the oldest result sits on the result
//   ports, and it is removed at an edge with pop high.
//   The installed version is loaded through cfg_we_i / cfg_idx_i / cfg_data_i
//   (major, minor, patch, build, valid at indexes 0..4) while the block idles;
//   other indexes are ignored.
// Timing:
//   One character per cycle, sustained while the parser is not held. The parser
//   consumes one character a cycle from a small front queue; the result of a
//   string passes the front queue, then the parse stage, whose compare feeds
//   the result queue directly, and then the result queue before it shows on
//   the result ports.
//   When the receiver stalls, results collect in the result queue, then the
//   parser holds on the next final character and the front queue fills, which
//   raises full. Reset empties both queues, clears the parser and zeroes the
//   installed version.

module version_string_parse_compare_unit #(
  parameter int unsigned MidDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        empty,
  input  logic        pop,
  output logic        version_ok_o,
  output logic        is_newer_o,
  output logic [31:0] major_number_o,
  output logic [31:0] minor_number_o,
  output logic [31:0] patch_number_o,
  output logic [31:0] build_number_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned ClassW  = $bits(vspc_pkg::char_class_t);
  localparam int unsigned ResultW = $bits(vspc_pkg::result_t);

  vspc_pkg::inst_cfg_t   cfg_q;
  vspc_pkg::char_class_t front_class, mid_data;
  vspc_pkg::result_t     back_result, out_data;
  logic [ClassW-1:0]     mid_rdata;
  logic [ResultW-1:0]    out_rdata;
  logic                  mid_empty, mid_pop;
  logic                  out_push, out_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vspc_pkg::CFG_MAJOR: cfg_q.major <= cfg_data_i;
        vspc_pkg::CFG_MINOR: cfg_q.minor <= cfg_data_i;
        vspc_pkg::CFG_PATCH: cfg_q.patch <= cfg_data_i;
        vspc_pkg::CFG_BUILD: cfg_q.build <= cfg_data_i;
        vspc_pkg::CFG_VALID: cfg_q.valid <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vspc_front u_front (
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .class_o     (front_class)
  );

  vspc_fifo #(
    .Width (ClassW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_class),
    .full_o  (full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_data = vspc_pkg::char_class_t'(mid_rdata);

  vspc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (!mid_empty),
    .mid_data_i  (mid_data),
    .mid_pop_o   (mid_pop),
    .cfg_i       (cfg_q),
    .out_push_o  (out_push),
    .result_o    (back_result),
    .out_full_i  (out_full)
  );

  vspc_fifo #(
    .Width (ResultW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_result),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_data       = vspc_pkg::result_t'(out_rdata);
  assign version_ok_o   = out_data.ok;
  assign is_newer_o     = out_data.newer;
  assign major_number_o = out_data.major;
  assign minor_number_o = out_data.minor;
  assign patch_number_o = out_data.patch;
  assign build_number_o = out_data.build;

  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result pushed into a full result queue");

  a_char_reaches_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !mid_empty)
    else $error("accepted request lost before the parser");

  a_newer_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_newer_o) |-> version_ok_o)
    else $error("newer flagged on an invalid version");

  a_fail_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !version_ok_o) |->
      (major_number_o == '0 && minor_number_o == '0 &&
       patch_number_o == '0 && build_number_o == '0))
    else $error("invalid version carries nonzero numbers");

  a_ok_build_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && version_ok_o) |-> (build_number_o != '0))
    else $error("valid version with zero suffix number");

endmodule

// ===== verif/tb.sv =====
// Testbench for version_string_parse_compare_unit: streams version strings one character
// at a time, predicts each verdict in a local parser model and checks every result.
// Depends on vspc_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;

  typedef logic [7:0] text_t [$];

  localparam int IdlePct     = 29;
  localparam int HoldCycles  = 300;
  localparam int Latency     = 3;
  localparam int RandomChars = 850;
  localparam int Radix       = 10;
  localparam int unsigned SuffixLen = vspc_pkg::SuffixLen;

  // parser phases of the local model
  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_MAJOR = 4'd1;
  localparam logic [3:0] PH_MINOR = 4'd2;
  localparam logic [3:0] PH_PATCH = 4'd3;
  localparam logic [3:0] PH_SFX   = 4'd4;
  localparam logic [3:0] PH_BUILD = 4'd12;
  localparam logic [3:0] PH_FAIL  = 4'd13;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  char_code_i = '0;
  logic        last_char_i = 1'b0;
  logic        empty;
  logic        pop         = 1'b0;
  logic        version_ok_o;
  logic        is_newer_o;
  logic [31:0] major_number_o;
  logic [31:0] minor_number_o;
  logic [31:0] patch_number_o;
  logic [31:0] build_number_o;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [31:0] cfg_data_i  = '0;

  // parser model state and installed version
  logic [3:0]  ph_q;
  logic [31:0] acc_q;
  logic [1:0]  ndig_q;
  logic        lead0_q;
  logic [31:0] caught_q [3];
  logic [31:0] inst_q [4];
  logic        inst_valid_q;

  vspc_pkg::result_t verdict_q [$];
  int      fail_cnt   = 0;
  int      chars_sent = 0;
  bit      gaps_on    = 1'b1;
  bit      hold_req   = 1'b0;
  int      hold_left  = 0;

  version_string_parse_compare_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .empty          (empty),
    .pop            (pop),
    .version_ok_o   (version_ok_o),
    .is_newer_o     (is_newer_o),
    .major_number_o (major_number_o),
    .minor_number_o (minor_number_o),
    .patch_number_o (patch_number_o),
    .build_number_o (build_number_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void clear_parser();
    ph_q    = PH_START;
    acc_q   = '0;
    ndig_q  = '0;
    lead0_q = 1'b0;
    foreach (caught_q[i]) caught_q[i] = '0;
  endfunction

  function automatic void clear_number();
    acc_q   = '0;
    ndig_q  = '0;
    lead0_q = 1'b0;
  endfunction

  // Fold one digit into the accumulator; 0 on overflow or a leading zero.
  function automatic bit take_digit(input logic [3:0] d);
    logic [31:0] d32;
    d32 = {28'd0, d};
    if (acc_q > (32'hFFFF_FFFF - d32) / Radix) return 1'b0;
    if (ndig_q != 0 && lead0_q) return 1'b0;
    if (ndig_q == 0) lead0_q = (d == 4'd0);
    acc_q = acc_q * Radix + d32;
    if (ndig_q < 2) ndig_q = ndig_q + 2'd1;
    return 1'b1;
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic lst);
    logic [3:0]        ph;
    logic              is_dig;
    logic              skip_v;
    int                idx;
    vspc_pkg::result_t r;
    is_dig = (c >= vspc_pkg::CH_ZERO) && (c <= vspc_pkg::CH_NINE);
    skip_v = 1'b0;
    if (ph_q == PH_START) begin
      ph_q   = PH_MAJOR;
      skip_v = (c == vspc_pkg::CH_V);
    end
    ph = ph_q;
    if (!skip_v) begin
      if (ph >= PH_MAJOR && ph <= PH_PATCH) begin
        if (is_dig) begin
          if (!take_digit(c[3:0])) ph_q = PH_FAIL;
        end else if (ndig_q == 0) begin
          ph_q = PH_FAIL;
        end else begin
          caught_q[ph - PH_MAJOR] = acc_q;
          clear_number();
          if (ph == PH_PATCH) begin
            ph_q = (c == vspc_pkg::SUFFIX_CHARS[0]) ? PH_SFX + 4'd1 : PH_FAIL;
          end else begin
            ph_q = (c == vspc_pkg::CH_DOT) ? ph + 4'd1 : PH_FAIL;
          end
        end
      end else if (ph >= PH_SFX && ph < PH_SFX + SuffixLen) begin
        idx = ph - PH_SFX;
        if (c != vspc_pkg::SUFFIX_CHARS[idx]) begin
          ph_q = PH_FAIL;
        end else begin
          ph_q = (idx == SuffixLen - 1) ? PH_BUILD : ph + 4'd1;
        end
      end else if (ph == PH_BUILD) begin
        if (!is_dig || !take_digit(c[3:0])) ph_q = PH_FAIL;
      end else begin
        ph_q = PH_FAIL;
      end
    end
    if (lst) begin
      r    = '0;
      r.ok = (ph_q == PH_BUILD) && (ndig_q != 0) && (acc_q != 0);
      if (r.ok) begin
        r.major = caught_q[0];
        r.minor = caught_q[1];
        r.patch = caught_q[2];
        r.build = acc_q;
        // four fields in order compare like one wide unsigned number
        r.newer = inst_valid_q &&
                  ({r.major, r.minor, r.patch, r.build} >
                   {inst_q[0], inst_q[1], inst_q[2], inst_q[3]});
      end
      verdict_q.push_back(r);
      clear_parser();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic void check_result();
    vspc_pkg::result_t want;
    if (verdict_q.size() == 0) begin
      $error("result with no string pending: version_ok %0b", version_ok_o);
      fail_cnt++;
      return;
    end
    want = verdict_q.pop_front();
    check_field("version_ok", 32'(want.ok), 32'(version_ok_o));
    check_field("is_newer", 32'(want.newer), 32'(is_newer_o));
    check_field("major_number", want.major, major_number_o);
    check_field("minor_number", want.minor, minor_number_o);
    check_field("patch_number", want.patch, patch_number_o);
    check_field("build_number", want.build, build_number_o);
  endfunction

  // Result side: check on every taken result, then pick the next pop.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_result();
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= !(gaps_on && $urandom_range(99) < IdlePct);
    end
  end

  // Hold each request until the edge that takes it.
  task automatic send_char(input logic [7:0] c, input logic lst);
    while (gaps_on && $urandom_range(99) < IdlePct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    char_code_i <= c;
    last_char_i <= lst;
    do @(posedge clk_i); while (full);
    chars_sent++;
    parse_char(c, lst);
  endtask

  task automatic send_text(input text_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      vspc_pkg::CFG_MAJOR: inst_q[0] = data;
      vspc_pkg::CFG_MINOR: inst_q[1] = data;
      vspc_pkg::CFG_PATCH: inst_q[2] = data;
      vspc_pkg::CFG_BUILD: inst_q[3] = data;
      vspc_pkg::CFG_VALID: inst_valid_q = data[0];
      default: ;
    endcase
  endtask

  task automatic load_installed(input logic [31:0] maj, input logic [31:0] mnr,
                                input logic [31:0] pat, input logic [31:0] bld,
                                input logic [31:0] vld_word);
    write_reg(vspc_pkg::CFG_MAJOR, maj);
    write_reg(vspc_pkg::CFG_MINOR, mnr);
    write_reg(vspc_pkg::CFG_PATCH, pat);
    write_reg(vspc_pkg::CFG_BUILD, bld);
    write_reg(vspc_pkg::CFG_VALID, vld_word);
    cfg_we_i <= 1'b0;
  endtask

  // head, then the first sfx_n separator characters, then tail
  function automatic text_t ver_text(string head, int sfx_n, string tail);
    text_t t;
    for (int i = 0; i < head.len(); i++) t.push_back(head[i]);
    for (int i = 0; i < sfx_n; i++) t.push_back(vspc_pkg::SUFFIX_CHARS[i]);
    for (int i = 0; i < tail.len(); i++) t.push_back(tail[i]);
    return t;
  endfunction

  // Mostly near the installed field so that compares land on every side.
  function automatic string field_text(int k);
    logic [31:0] v;
    int          pick;
    string       t;
    pick = $urandom_range(99);
    if (pick < 35) v = inst_q[k];
    else if (pick < 50) v = inst_q[k] + 1;
    else if (pick < 65) v = inst_q[k] - 1;
    else if (pick < 85) v = $urandom_range(20);
    else v = $urandom();
    t    = $sformatf("%0d", v);
    pick = $urandom_range(99);
    if (pick < 4) t = {"0", t};
    else if (pick < 8) t = $sformatf("429496729%0d", $urandom_range(9));
    return t;
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(3))
      0: return 8'(vspc_pkg::CH_ZERO + $urandom_range(9));
      1: return vspc_pkg::SUFFIX_CHARS[$urandom_range(SuffixLen - 1)];
      2: return $urandom_range(1) ? vspc_pkg::CH_V : vspc_pkg::CH_DOT;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_string(output text_t s);
    int    kind;
    int    pos;
    string head;
    kind = $urandom_range(99);
    if (kind < 85) begin
      head = "";
      if ($urandom_range(1)) head = "v";
      head = {head, field_text(0), ".", field_text(1), ".", field_text(2)};
      s    = ver_text(head, SuffixLen, field_text(3));
      // break a well-formed string in one spot
      if (kind >= 70) begin
        pos = $urandom_range(s.size() - 1);
        case ($urandom_range(4))
          0: s[pos] = pick_char();
          1: if (s.size() > 1) s.delete(pos);
          2: s.insert(pos, pick_char());
          3: while (s.size() > pos + 1) void'(s.pop_back());
          default: s.push_back(pick_char());
        endcase
      end
    end else begin
      s.delete();
      repeat ($urandom_range(1, 16)) s.push_back(pick_char());
    end
  endtask

  task automatic test_defaults();
    // installed version is invalid out of reset, so nothing is newer
    send_text(ver_text("v1.2.3", SuffixLen, "4"));
    send_text(ver_text("0.0.0", SuffixLen, "1"));
    drain_results();
  endtask

  task automatic test_format();
    load_installed(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    send_text(ver_text("4294967295.4294967295.4294967295", SuffixLen, "4294967295"));
    send_text(ver_text("4294967296.0.0", SuffixLen, "1"));
    send_text(ver_text("1.2.3", SuffixLen, "42949672950"));
    send_text(ver_text("01.2.3", SuffixLen, "4"));
    send_text(ver_text("1.2.3", SuffixLen, "007"));
    send_text(ver_text("1.2.3", SuffixLen, "0"));
    send_text(ver_text("1..3", SuffixLen, "1"));
    send_text(ver_text("1.2", SuffixLen, "1"));
    send_text(ver_text("1.2.3", SuffixLen, "1x"));
    send_text(ver_text("vv1.2.3", SuffixLen, "1"));
    send_text(ver_text("1.v2.3", SuffixLen, "1"));
    send_text(ver_text("V1.2.3", SuffixLen, "1"));
    send_text(ver_text("1.2.3", 4, ""));
    send_text(ver_text("1.2.3", SuffixLen, ""));
    send_text(ver_text("1.2.3.4", 0, ""));
    send_text(ver_text("v", 0, ""));
    send_text(ver_text("x", 0, ""));
    // a failed string must not leak into the next one
    send_text(ver_text("10.20.30", SuffixLen, "10"));
    drain_results();
  endtask

  task automatic test_compare();
    load_installed(32'd5, 32'd5, 32'd5, 32'd5, 32'hFFFF_FFFF);
    send_text(ver_text("5.5.5", SuffixLen, "5"));
    send_text(ver_text("5.5.5", SuffixLen, "6"));
    send_text(ver_text("5.5.5", SuffixLen, "4"));
    send_text(ver_text("5.5.6", SuffixLen, "1"));
    send_text(ver_text("5.5.4", SuffixLen, "9"));
    send_text(ver_text("5.6.0", SuffixLen, "1"));
    send_text(ver_text("5.4.9", SuffixLen, "9"));
    send_text(ver_text("6.0.0", SuffixLen, "1"));
    send_text(ver_text("4.9.9", SuffixLen, "9"));
    drain_results();
    // valid bit clear while the upper data bits are set
    load_installed(32'd5, 32'd5, 32'd5, 32'd5, 32'hFFFF_FFFE);
    send_text(ver_text("9.9.9", SuffixLen, "9"));
    drain_results();
  endtask

  task automatic test_stray_index();
    load_installed(32'd7, 32'd0, 32'd0, 32'd1, 32'd1);
    for (int i = int'(vspc_pkg::CFG_VALID) + 1; i < 8; i++) write_reg(i[2:0], $urandom());
    cfg_we_i <= 1'b0;
    send_text(ver_text("7.0.0", SuffixLen, "2"));
    send_text(ver_text("7.0.0", SuffixLen, "1"));
    drain_results();
  endtask

  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 1; i <= 12; i++) send_text(ver_text("3.1.4", SuffixLen, $sformatf("%0d", i)));
    gaps_on = 1'b1;
    drain_results();
  endtask

  task automatic test_random();
    text_t s;
    int    goal;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0, 4: load_installed($urandom_range(9), $urandom_range(9), $urandom_range(9),
                             $urandom_range(1, 9), $urandom() | 32'h1);
        1: load_installed('1, '1, '1, '1, $urandom() | 32'h1);
        2: load_installed('0, '0, '0, '0, $urandom() | 32'h1);
        default: load_installed($urandom(), $urandom(), $urandom(), $urandom(),
                                $urandom() & ~32'h1);
      endcase
      gaps_on = (phase != 3);
      goal    = chars_sent + RandomChars / 5;
      while (chars_sent < goal) begin
        random_string(s);
        send_text(s);
      end
      drain_results();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    foreach (inst_q[i]) inst_q[i] = '0;
    inst_valid_q = 1'b0;
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_format();
    test_compare();
    test_stray_index();
    test_backpressure();
    test_random();
    if (fail_cnt == 0) begin
      $display("version_string_parse_compare_unit verification clean");
    end else begin
      $display("version_string_parse_compare_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("version_string_parse_compare_unit verification failed");
    $finish;
  end

endmodule

// ===== version_string_parse_compare_unit.f =====
rtl/vspc_pkg.sv
rtl/vspc_fifo.sv
rtl/vspc_front.sv
rtl/vspc_back.sv
rtl/version_string_parse_compare_unit.sv
verif/tb.sv
